// ===== design/i2cmbc_pkg.sv =====
package i2cmbc_pkg;

   localparam int HALF_PERIOD_WIDTH = 16;
   localparam logic [HALF_PERIOD_WIDTH-1:0] HALF_PERIOD_RESET = 16'd100;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [12:0] {
      PH_IDLE     = 13'b0000000000001,
      PH_ST_A     = 13'b0000000000010,
      PH_ST_B     = 13'b0000000000100,
      PH_SP_A     = 13'b0000000001000,
      PH_SP_B     = 13'b0000000010000,
      PH_WR_LOW   = 13'b0000000100000,
      PH_WR_HIGH  = 13'b0000001000000,
      PH_WR_ACKLO = 13'b0000010000000,
      PH_WR_ACKHI = 13'b0000100000000,
      PH_RD_HIGH  = 13'b0001000000000,
      PH_RD_LOW   = 13'b0010000000000,
      PH_RD_ACKLO = 13'b0100000000000,
      PH_RD_ACKHI = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } req_word_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_bit;
      logic       cmd_rejected;
   } rsp_word_type;

endpackage

// ===== design/i2cmbc_chan_if.sv =====
interface i2cmbc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/i2cmbc_engine.sv =====
module i2cmbc_engine (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           step,
   input  i2cmbc_pkg::req_word_type                       item,
   input  logic [i2cmbc_pkg::HALF_PERIOD_WIDTH-1:0]       half_period,
   output i2cmbc_pkg::rsp_word_type                       result
);
   import i2cmbc_pkg::*;

   phase_type                    phase_ff, phase_in;
   logic [3:0]                   bit_count_ff, bit_count_in;
   logic [7:0]                   shift_ff, shift_in;
   logic [HALF_PERIOD_WIDTH-1:0] wait_count_ff, wait_count_in;
   logic                         scl_ff, scl_in;
   logic                         sda_ff, sda_in;
   logic                         ack_hold_ff, ack_hold_in;
   logic                         ack_choice_ff, ack_choice_in;
   logic [7:0]                   rx_hold_ff, rx_hold_in;
   logic                         done, rejected;
   logic [HALF_PERIOD_WIDTH-1:0] wait_load;
   logic [3:0]                   bit_next;
   logic                         is_cmd;

   // zero half period behaves as one
   assign wait_load = (half_period == '0) ? HALF_PERIOD_WIDTH'(1) : half_period;
   assign bit_next  = bit_count_ff + 4'd1;
   assign is_cmd    = (item.operation == OP_START) || (item.operation == OP_STOP) ||
                      (item.operation == OP_WRITE) || (item.operation == OP_READ);

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      wait_count_in = wait_count_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      ack_hold_in   = ack_hold_ff;
      ack_choice_in = ack_choice_ff;
      rx_hold_in    = rx_hold_ff;
      done          = 1'b0;
      rejected      = 1'b0;
      if (phase_ff != PH_IDLE) begin
         rejected = is_cmd;
         if (wait_count_ff > HALF_PERIOD_WIDTH'(1)) begin
            wait_count_in = wait_count_ff - HALF_PERIOD_WIDTH'(1);
         end else begin
            wait_count_in = '0;
            unique case (phase_ff)
               PH_ST_A: begin
                  sda_in = 1'b0;
                  wait_count_in = wait_load;
                  phase_in = PH_ST_B;
               end
               PH_ST_B: begin
                  scl_in = 1'b0;
                  phase_in = PH_IDLE;
                  done = 1'b1;
               end
               PH_SP_A: begin
                  sda_in = 1'b1;
                  wait_count_in = wait_load;
                  phase_in = PH_SP_B;
               end
               PH_SP_B: begin
                  phase_in = PH_IDLE;
                  done = 1'b1;
               end
               PH_WR_LOW: begin
                  scl_in = 1'b1;
                  wait_count_in = wait_load;
                  phase_in = PH_WR_HIGH;
               end
               PH_WR_HIGH: begin
                  scl_in = 1'b0;
                  bit_count_in = bit_next;
                  wait_count_in = wait_load;
                  if (!bit_next[3]) begin
                     sda_in = shift_ff[3'(3'd7 - bit_next[2:0])];
                     phase_in = PH_WR_LOW;
                  end else begin
                     sda_in = 1'b1;
                     phase_in = PH_WR_ACKLO;
                  end
               end
               PH_WR_ACKLO: begin
                  scl_in = 1'b1;
                  ack_hold_in = item.sda_in;
                  wait_count_in = wait_load;
                  phase_in = PH_WR_ACKHI;
               end
               PH_WR_ACKHI: begin
                  scl_in = 1'b0;
                  phase_in = PH_IDLE;
                  done = 1'b1;
               end
               PH_RD_HIGH: begin
                  shift_in = {shift_ff[6:0], item.sda_in};
                  scl_in = 1'b0;
                  wait_count_in = wait_load;
                  phase_in = PH_RD_LOW;
               end
               PH_RD_LOW: begin
                  bit_count_in = bit_next;
                  wait_count_in = wait_load;
                  if (!bit_next[3]) begin
                     scl_in = 1'b1;
                     phase_in = PH_RD_HIGH;
                  end else begin
                     sda_in = !ack_choice_ff;
                     phase_in = PH_RD_ACKLO;
                  end
               end
               PH_RD_ACKLO: begin
                  scl_in = 1'b1;
                  wait_count_in = wait_load;
                  phase_in = PH_RD_ACKHI;
               end
               PH_RD_ACKHI: begin
                  scl_in = 1'b0;
                  sda_in = 1'b1;
                  rx_hold_in = shift_ff;
                  phase_in = PH_IDLE;
                  done = 1'b1;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end else begin
         unique case (item.operation)
            OP_START: begin
               sda_in = 1'b1;
               scl_in = 1'b1;
               wait_count_in = wait_load;
               phase_in = PH_ST_A;
            end
            OP_STOP: begin
               sda_in = 1'b0;
               scl_in = 1'b1;
               wait_count_in = wait_load;
               phase_in = PH_SP_A;
            end
            OP_WRITE: begin
               shift_in = item.tx_byte;
               bit_count_in = '0;
               sda_in = item.tx_byte[7];
               wait_count_in = wait_load;
               phase_in = PH_WR_LOW;
            end
            OP_READ: begin
               shift_in = '0;
               bit_count_in = '0;
               ack_choice_in = item.send_ack;
               sda_in = 1'b1;
               scl_in = 1'b1;
               wait_count_in = wait_load;
               phase_in = PH_RD_HIGH;
            end
            default: ;
         endcase
      end
   end

   assign result.scl_out      = scl_in;
   assign result.sda_out      = sda_in;
   assign result.busy_res     = (phase_in != PH_IDLE);
   assign result.done_res     = done;
   assign result.rx_byte      = rx_hold_in;
   assign result.ack_bit      = ack_hold_in;
   assign result.cmd_rejected = rejected;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         wait_count_ff <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         ack_hold_ff   <= 1'b1;
         ack_choice_ff <= 1'b0;
         rx_hold_ff    <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         wait_count_ff <= wait_count_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         ack_hold_ff   <= ack_hold_in;
         ack_choice_ff <= ack_choice_in;
         rx_hold_ff    <= rx_hold_in;
      end
   end

`ifndef SYNTHESIS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      step && result.done_res |-> !result.busy_res)
      else $error("done raised while still busy");
   a_no_reject_idle: assert property (@(posedge clock) disable iff (reset)
      step && (phase_ff == PH_IDLE) |-> !result.cmd_rejected)
      else $error("command rejected while idle");
   a_wait_armed: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (wait_count_ff != '0))
      else $error("active phase with no wait pending");
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WR_LOW) || (phase_ff == PH_RD_HIGH) |-> !bit_count_ff[3])
      else $error("bit counter past last data bit");
`endif

endmodule

// ===== design/i2c_master_byte_controller_top.sv =====
// channel | role   | word                               | handshake
// req_if  | input  | operation, tx_byte, send_ack, sda  | valid/ready
// rsp_if  | output | scl, sda, busy, done, rx, ack, rej | valid/ready
// csr_if  | input  | half_period_ticks (16 bit)         | valid/ready, ready when input reg empty
//
// one tick accepted per cycle while the result side is not stalled; a tick's result word
// passes through the input register, then the result register after the bus sequencer
// reset is synchronous and active high: bus released, half period 100
// a stalled result holds the result register and backs up into the input
// register; the sequencer only advances when a tick moves to the result side
module i2c_master_byte_controller_top (
   input logic          clock,
   input logic          reset,
   i2cmbc_chan_if.sink   req_if,
   i2cmbc_chan_if.source rsp_if,
   i2cmbc_chan_if.sink   csr_if
);
   import i2cmbc_pkg::*;

   logic                         in_valid_ff, in_valid_in;
   req_word_type                 in_word_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_word_type                 rsp_word_ff;
   logic [HALF_PERIOD_WIDTH-1:0] half_period_ff;
   logic                         advance;
   rsp_word_type                 step_result;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   // no half period change while a tick waits in the input register
   assign csr_if.ready  = !in_valid_ff;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_word_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         half_period_ff <= HALF_PERIOD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            half_period_ff <= csr_if.payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_word_ff <= req_if.payload;
      end
      if (advance) begin
         rsp_word_ff <= step_result;
      end
   end

   i2cmbc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (in_word_ff),
      .half_period (half_period_ff),
      .result      (step_result)
   );

endmodule

// ===== tb/sv/i2cmbc_bus_checker.sv =====
`timescale 1ns / 1ps

module i2cmbc_bus_checker (
   input  logic        clock,
   input  logic        reset,
   i2cmbc_chan_if      req_if,
   i2cmbc_chan_if      rsp_if,
   i2cmbc_chan_if      csr_if,
   output int unsigned error_count,
   output int unsigned words_pending
);
   import i2cmbc_pkg::*;

   logic [15:0]  half_ticks;
   phase_type    ph;
   logic [3:0]   bit_idx;
   logic [7:0]   shifter;
   logic [15:0]  wait_left;
   logic         scl_lvl;
   logic         sda_lvl;
   logic         ack_seen;
   logic         ack_drive;
   logic [7:0]   rx_last;
   rsp_word_type bus_words[$];
   int unsigned  rsp_seen;

   function automatic void load_wait(phase_type nxt);
      wait_left = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
      ph = nxt;
   endfunction

   function automatic logic next_tx_bit();
      return shifter[3'd7 - bit_idx[2:0]];
   endfunction

   function automatic rsp_word_type advance_bus(req_word_type w);
      rsp_word_type r;
      logic done;
      logic rej;
      done = 1'b0;
      rej = 1'b0;
      if (ph != PH_IDLE) begin
         // commands are turned away up to and including the done tick
         rej = (w.operation >= OP_START && w.operation <= OP_READ);
         if (wait_left > 16'd1) begin
            wait_left = wait_left - 16'd1;
         end else begin
            wait_left = 16'd0;
            case (ph)
               PH_ST_A: begin
                  sda_lvl = 1'b0;
                  load_wait(PH_ST_B);
               end
               PH_ST_B: begin
                  scl_lvl = 1'b0;
                  ph = PH_IDLE;
                  done = 1'b1;
               end
               PH_SP_A: begin
                  sda_lvl = 1'b1;
                  load_wait(PH_SP_B);
               end
               PH_SP_B: begin
                  ph = PH_IDLE;
                  done = 1'b1;
               end
               PH_WR_LOW: begin
                  scl_lvl = 1'b1;
                  load_wait(PH_WR_HIGH);
               end
               PH_WR_HIGH: begin
                  scl_lvl = 1'b0;
                  bit_idx = bit_idx + 4'd1;
                  if (bit_idx < 4'd8) begin
                     sda_lvl = next_tx_bit();
                     load_wait(PH_WR_LOW);
                  end else begin
                     sda_lvl = 1'b1;
                     load_wait(PH_WR_ACKLO);
                  end
               end
               PH_WR_ACKLO: begin
                  scl_lvl = 1'b1;
                  ack_seen = w.sda_in;
                  load_wait(PH_WR_ACKHI);
               end
               PH_WR_ACKHI: begin
                  scl_lvl = 1'b0;
                  ph = PH_IDLE;
                  done = 1'b1;
               end
               PH_RD_HIGH: begin
                  shifter = {shifter[6:0], w.sda_in};
                  scl_lvl = 1'b0;
                  load_wait(PH_RD_LOW);
               end
               PH_RD_LOW: begin
                  bit_idx = bit_idx + 4'd1;
                  if (bit_idx < 4'd8) begin
                     scl_lvl = 1'b1;
                     load_wait(PH_RD_HIGH);
                  end else begin
                     sda_lvl = ~ack_drive;
                     load_wait(PH_RD_ACKLO);
                  end
               end
               PH_RD_ACKLO: begin
                  scl_lvl = 1'b1;
                  load_wait(PH_RD_ACKHI);
               end
               PH_RD_ACKHI: begin
                  scl_lvl = 1'b0;
                  sda_lvl = 1'b1;
                  rx_last = shifter;
                  ph = PH_IDLE;
                  done = 1'b1;
               end
               default: ph = PH_IDLE;
            endcase
         end
      end else begin
         case (w.operation)
            OP_START: begin
               sda_lvl = 1'b1;
               scl_lvl = 1'b1;
               load_wait(PH_ST_A);
            end
            OP_STOP: begin
               sda_lvl = 1'b0;
               scl_lvl = 1'b1;
               load_wait(PH_SP_A);
            end
            OP_WRITE: begin
               shifter = w.tx_byte;
               bit_idx = 4'd0;
               sda_lvl = next_tx_bit();
               load_wait(PH_WR_LOW);
            end
            OP_READ: begin
               shifter = 8'h00;
               bit_idx = 4'd0;
               ack_drive = w.send_ack;
               sda_lvl = 1'b1;
               scl_lvl = 1'b1;
               load_wait(PH_RD_HIGH);
            end
            default: ;
         endcase
      end
      r.scl_out = scl_lvl;
      r.sda_out = sda_lvl;
      r.busy_res = (ph != PH_IDLE);
      r.done_res = done;
      r.rx_byte = rx_last;
      r.ack_bit = ack_seen;
      r.cmd_rejected = rej;
      return r;
   endfunction

   function automatic string show_word(rsp_word_type x);
      return $sformatf("scl %b sda %b busy %b done %b rx %02h ack %b rej %b",
                       x.scl_out, x.sda_out, x.busy_res, x.done_res, x.rx_byte,
                       x.ack_bit, x.cmd_rejected);
   endfunction

   task automatic check_word(rsp_word_type got);
      rsp_word_type want;
      rsp_seen++;
      if (bus_words.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("result word %0d with nothing predicted: %s", rsp_seen, show_word(got));
      end else begin
         want = bus_words.pop_front();
         if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
             got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
             got.rx_byte !== want.rx_byte || got.ack_bit !== want.ack_bit ||
             got.cmd_rejected !== want.cmd_rejected) begin
            error_count++;
            if (error_count <= 10) begin
               $display("result word %0d mismatch", rsp_seen);
               $display("   expected %s", show_word(want));
               $display("   actual   %s", show_word(got));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         half_ticks = HALF_PERIOD_RESET;
         ph = PH_IDLE;
         bit_idx = 4'd0;
         shifter = 8'h00;
         wait_left = 16'd0;
         scl_lvl = 1'b1;
         sda_lvl = 1'b1;
         ack_seen = 1'b1;
         ack_drive = 1'b0;
         rx_last = 8'h00;
         bus_words.delete();
         rsp_seen = 0;
         error_count = 0;
         words_pending = 0;
      end else begin
         if (csr_if.valid && csr_if.ready)
            half_ticks = csr_if.payload;
         if (req_if.valid && req_if.ready)
            bus_words.push_back(advance_bus(req_if.payload));
         if (rsp_if.valid && rsp_if.ready)
            check_word(rsp_if.payload);
         words_pending = bus_words.size();
      end
   end

endmodule

// ===== tb/sv/tb_i2c_master_byte_controller_top.sv =====
`timescale 1ns / 1ps

module tb_i2c_master_byte_controller_top;
   import i2cmbc_pkg::*;

   logic        clock;
   logic        reset;
   logic [15:0] cur_half;
   bit          steady;
   int unsigned hold_requests;
   int unsigned items_sent;
   int unsigned error_count;
   int unsigned words_pending;

   i2cmbc_chan_if #(.payload_type(req_word_type)) req_if ();
   i2cmbc_chan_if #(.payload_type(rsp_word_type)) rsp_if ();
   i2cmbc_chan_if #(.payload_type(logic [HALF_PERIOD_WIDTH-1:0])) csr_if ();

   i2c_master_byte_controller_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   i2cmbc_bus_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .csr_if        (csr_if),
      .error_count   (error_count),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // result side: random stalls, occasional long ones, and a requested long hold
   initial begin
      int hold_left;
      int unsigned hold_served;
      hold_left = 0;
      hold_served = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
         end else if (steady) begin
            rsp_if.ready = 1'b1;
         end else if ($urandom_range(0, 99) < 2) begin
            rsp_if.ready = 1'b0;
            hold_left = $urandom_range(8, 30);
         end else begin
            rsp_if.ready = ($urandom_range(0, 3) != 0);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int cmd_span(logic [2:0] op);
      int eff;
      eff = (cur_half == 16'd0) ? 1 : int'(cur_half);
      if (op == OP_START || op == OP_STOP)
         return 2 * eff;
      if (op == OP_WRITE || op == OP_READ)
         return 18 * eff;
      return 0;
   endfunction

   task automatic send_word(input logic [2:0] op, input logic [7:0] txb,
                            input logic ack, input logic sda);
      req_word_type w;
      int gap;
      gap = pick_gap();
      w.operation = op;
      w.tx_byte = txb;
      w.send_ack = ack;
      w.sda_in = sda;
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.payload = w;
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // sda_sel below zero means a random line level on every tick
   task automatic tick_n(input int n, input int sda_sel);
      repeat (n)
         send_word(OP_TICK, 8'($urandom), 1'($urandom),
                   (sda_sel < 0) ? logic'($urandom) : logic'(sda_sel));
   endtask

   task automatic run_cmd(input logic [2:0] op, input logic [7:0] txb,
                          input logic ack, input int sda_sel);
      send_word(op, txb, ack, (sda_sel < 0) ? logic'($urandom) : logic'(sda_sel));
      tick_n(cmd_span(op) + 1, sda_sel);
   endtask

   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (words_pending != 0) @(negedge clock);
   endtask

   task automatic set_half(input logic [15:0] value);
      wait_drained();
      csr_if.payload = value;
      csr_if.valid = 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
      cur_half = value;
   endtask

   initial begin
      int unsigned seg_start;
      int span;
      logic [2:0] op;
      logic [15:0] seg_half[5];
      bit paused;
      seg_half = '{16'd1, 16'd2, 16'd3, 16'd1, 16'd4};
      paused = 1'b0;
      reset = 1'b1;
      steady = 1'b0;
      hold_requests = 0;
      items_sent = 0;
      cur_half = HALF_PERIOD_RESET;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // one start at the reset half period
      run_cmd(OP_START, 8'h00, 1'b0, -1);

      set_half(16'd1);
      run_cmd(OP_START, 8'($urandom), 1'($urandom), -1);
      run_cmd(OP_WRITE, 8'hFF, 1'b0, 0);
      run_cmd(OP_WRITE, 8'h00, 1'b1, 1);
      run_cmd(OP_WRITE, 8'hA5, 1'b0, -1);
      run_cmd(OP_READ, 8'h00, 1'b1, 1);
      run_cmd(OP_READ, 8'hFF, 1'b0, 0);
      run_cmd(OP_READ, 8'($urandom), 1'($urandom), -1);
      run_cmd(OP_STOP, 8'($urandom), 1'($urandom), -1);

      // busy rejection, including a command on the done tick
      steady = 1'b1;
      send_word(OP_START, 8'h00, 1'b0, 1'b1);
      send_word(OP_STOP, 8'h00, 1'b0, 1'b1);
      send_word(OP_WRITE, 8'h5A, 1'b0, 1'b1);
      // unused codes, idle then busy
      send_word(3'd5, 8'hFF, 1'b1, 1'b0);
      send_word(3'd6, 8'h00, 1'b0, 1'b1);
      send_word(3'd7, 8'h81, 1'b1, 1'b0);
      send_word(OP_READ, 8'h00, 1'b1, 1'b1);
      send_word(3'd6, 8'h00, 1'b0, 1'b0);
      send_word(OP_START, 8'h00, 1'b0, 1'b0);
      tick_n(20, -1);
      steady = 1'b0;

      // zero half period waits one tick
      set_half(16'd0);
      run_cmd(OP_START, 8'($urandom), 1'($urandom), -1);
      run_cmd(OP_WRITE, 8'h3C, 1'($urandom), -1);

      // long half period, shortened mid-command for the second wait
      steady = 1'b1;
      set_half(16'd40);
      send_word(OP_START, 8'h00, 1'b0, 1'b1);
      tick_n(10, -1);
      set_half(16'd2);
      tick_n(36, -1);
      steady = 1'b0;

      // random transactions, each command followed by ticks covering it
      for (int s = 0; s < 5; s++) begin
         set_half(seg_half[s]);
         steady = (s == 3);
         if (s == 1)
            hold_requests++;
         seg_start = items_sent;
         while (items_sent - seg_start < 60) begin
            if (s == 2 && !paused && items_sent - seg_start > 30) begin
               paused = 1'b1;
               wait_drained();
            end
            op = 3'($urandom_range(int'(OP_START), int'(OP_READ)));
            send_word(op, 8'($urandom), 1'($urandom), 1'($urandom));
            span = cmd_span(op) + $urandom_range(0, 3);
            for (int i = 0; i < span; i++) begin
               // stray commands mostly land while busy and get rejected
               if ($urandom_range(0, 99) < 6)
                  send_word(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom),
                            1'($urandom));
               else
                  send_word(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
            end
         end
      end
      steady = 1'b0;

      wait_drained();
      repeat (10) @(negedge clock);
      if (error_count == 0 && words_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
